FILE: sv/rotary_encoder_menu_controller_assert.svh
// assertion macros shared by the checker
`ifndef ROTARY_ENCODER_MENU_CONTROLLER_ASSERT_SVH
`define ROTARY_ENCODER_MENU_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define REM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rem check failed");

// next-cycle implication, checked while out of reset
`define REM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rem check failed");

`endif

FILE: sv/rem_pkg.sv
package rem_pkg;

   localparam int PAGE_COUNT = 7;
   localparam int INDEX_MAX  = 15;
   localparam int PAGE_W     = 3;
   localparam int IDX_W      = $clog2(INDEX_MAX + 1);
   localparam int TIME_W     = 32;

   localparam logic [PAGE_W-1:0] PAGE_LAST    = PAGE_W'(PAGE_COUNT - 1);
   localparam logic [IDX_W-1:0]  INDEX_LAST   = IDX_W'(INDEX_MAX);

   // page codes
   localparam logic [PAGE_W-1:0] PG_STATUS    = 3'd0;
   localparam logic [PAGE_W-1:0] PG_IDENTITY  = 3'd1;
   localparam logic [PAGE_W-1:0] PG_MODE      = 3'd2;
   localparam logic [PAGE_W-1:0] PG_EXCITE    = 3'd3;
   localparam logic [PAGE_W-1:0] PG_STREAM    = 3'd4;
   localparam logic [PAGE_W-1:0] PG_DUMP      = 3'd5;
   localparam logic [PAGE_W-1:0] PG_CALIBRATE = 3'd6;

   // register indexes on the csr port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BTN_PERIOD   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUIET_TURN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_QUIET_CHANGE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REDRAW       = 3'd4;

   // register reset values
   localparam logic [7:0] SETTLE_RST       = 8'd25;
   localparam logic [7:0] BTN_PERIOD_RST   = 8'd30;
   localparam logic [9:0] QUIET_TURN_RST   = 10'd200;
   localparam logic [9:0] QUIET_CHANGE_RST = 10'd50;
   localparam logic [7:0] REDRAW_RST       = 8'd40;

   // transition table entries that decode to a step of minus one,
   // indexed by {settled level, new level}; every other change is plus one
   localparam logic [15:0] QUAD_DOWN = 16'h4182;

   typedef struct packed {
      logic [7:0] level_hold_ms;
      logic [7:0] button_period_ms;
      logic [9:0] quiet_turn_ms;
      logic [9:0] quiet_change_ms;
      logic [7:0] redraw_ms;
   } cfg_type;

   typedef struct packed {
      logic              step;
      logic              up;
      logic [TIME_W-1:0] since_change;
      logic [TIME_W-1:0] since_turn;
   } quad_type;

   typedef struct packed {
      logic              redraw;
      logic              map_req;
      logic              dump_req;
      logic              fire_req;
      logic              verify_req;
      logic              streaming_on;
      logic              held_mode;
      logic              editing;
      logic [3:0]        edit_index;
      logic [PAGE_W-1:0] page;
   } result_type;

endpackage

FILE: sv/rem_quad.sv
module rem_quad (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           upd,
   input  logic [rem_pkg::TIME_W-1:0]     now_ms,
   input  logic                           enc_a,
   input  logic                           enc_b,
   input  logic [7:0]                     level_hold_ms,
   output rem_pkg::quad_type              quad
);

   logic [1:0]                   raw;
   logic                         level_valid_ff, level_valid_in;
   logic [1:0]                   last_level_ff, last_level_in;
   logic [1:0]                   settled_ff, settled_in;
   logic                         have_settled_ff, have_settled_in;
   logic [rem_pkg::TIME_W-1:0]   change_time_ff, change_time_in;
   logic [rem_pkg::TIME_W-1:0]   last_turn_ff, last_turn_in;
   logic                         chg;
   logic                         settled;

   function automatic logic QUAD_DOWN_BIT(input logic [1:0] from, input logic [1:0] to);
      logic [3:0] idx;
      idx = {from, to};
      return rem_pkg::QUAD_DOWN[idx];
   endfunction

   assign raw = {enc_a, enc_b};

   always_comb begin
      chg               = !level_valid_ff || (raw != last_level_ff);
      quad.since_change = chg ? '0 : now_ms - change_time_ff;
      settled           = quad.since_change >= {24'd0, level_hold_ms};
      quad.step         = settled && have_settled_ff && (raw != settled_ff);
      quad.up           = !QUAD_DOWN_BIT(settled_ff, raw);
      quad.since_turn   = quad.step ? '0 : now_ms - last_turn_ff;

      level_valid_in  = 1'b1;
      last_level_in   = raw;
      change_time_in  = chg ? now_ms : change_time_ff;
      have_settled_in = have_settled_ff || settled;
      settled_in      = settled ? raw : settled_ff;
      last_turn_in    = quad.step ? now_ms : last_turn_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_valid_ff  <= 1'b0;
         settled_ff      <= 2'd0;
         have_settled_ff <= 1'b0;
         change_time_ff  <= '0;
         last_turn_ff    <= '0;
      end else if (upd) begin
         level_valid_ff  <= level_valid_in;
         settled_ff      <= settled_in;
         have_settled_ff <= have_settled_in;
         change_time_ff  <= change_time_in;
         last_turn_ff    <= last_turn_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd) begin
         last_level_ff <= last_level_in;
      end
   end

endmodule

FILE: sv/rem_menu.sv
module rem_menu (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           upd,
   input  logic [rem_pkg::TIME_W-1:0]     now_ms,
   input  logic                           enc_switch,
   input  logic                           confirm_btn,
   input  logic                           return_btn,
   input  rem_pkg::quad_type              quad,
   input  rem_pkg::cfg_type               cfg,
   output rem_pkg::result_type            result
);

   logic [rem_pkg::PAGE_W-1:0]   page_ff, page_in, page_turn;
   logic [rem_pkg::IDX_W-1:0]    index_ff, index_in;
   logic                         edit_ff, edit_in, edit_turn;
   logic                         held_ff, held_in;
   logic                         stream_ff, stream_in;
   logic [rem_pkg::TIME_W-1:0]   last_button_ff, last_button_in;
   logic [rem_pkg::TIME_W-1:0]   last_draw_ff, last_draw_in;
   logic [2:0]                   prev_btn_ff, prev_btn_in;
   logic                         due, quiet, act, ret, draw_clr, redraw;
   logic                         vreq, freq, dreq, mreq;
   logic [rem_pkg::TIME_W-1:0]   draw_base;
   logic [7:0]                   index_wide;

   always_comb begin
      // turn step: edit index while editing on the excite page, else move the page
      page_turn = page_ff;
      edit_turn = edit_ff;
      index_in  = index_ff;
      if (quad.step) begin
         if (edit_ff && page_ff == rem_pkg::PG_EXCITE) begin
            if (quad.up) begin
               index_in = (index_ff >= rem_pkg::INDEX_LAST) ? '0 : index_ff + 1'b1;
            end else begin
               index_in = (index_ff == '0 || index_ff > rem_pkg::INDEX_LAST) ?
                          rem_pkg::INDEX_LAST : index_ff - 1'b1;
            end
         end else begin
            edit_turn = 1'b0;
            if (quad.up) begin
               page_turn = (page_ff >= rem_pkg::PAGE_LAST) ? '0 : page_ff + 1'b1;
            end else begin
               page_turn = (page_ff == '0) ? rem_pkg::PAGE_LAST : page_ff - 1'b1;
            end
         end
      end

      // button sampling window, prev_btn is {switch, return, confirm}
      due   = (now_ms - last_button_ff) > {24'd0, cfg.button_period_ms};
      quiet = (quad.since_turn > {22'd0, cfg.quiet_turn_ms}) &&
              (quad.since_change > {22'd0, cfg.quiet_change_ms});
      act   = due && quiet && ((!confirm_btn && prev_btn_ff[0]) ||
                               (!enc_switch && prev_btn_ff[2]));
      ret   = due && !return_btn && prev_btn_ff[1];

      last_button_in = due ? now_ms : last_button_ff;
      prev_btn_in    = due ? {enc_switch, return_btn, confirm_btn} : prev_btn_ff;

      page_in   = page_turn;
      edit_in   = edit_turn;
      held_in   = held_ff;
      stream_in = stream_ff;
      vreq      = 1'b0;
      freq      = 1'b0;
      dreq      = 1'b0;
      mreq      = 1'b0;
      if (act) begin
         unique case (page_turn)
            rem_pkg::PG_IDENTITY:  vreq = 1'b1;
            rem_pkg::PG_MODE:      held_in = !held_ff;
            rem_pkg::PG_EXCITE: begin
               edit_in = !edit_turn;
               freq    = edit_turn;
            end
            rem_pkg::PG_STREAM:    stream_in = !stream_ff;
            rem_pkg::PG_DUMP:      dreq = 1'b1;
            rem_pkg::PG_CALIBRATE: mreq = 1'b1;
            default: ;
         endcase
      end
      if (ret) begin
         edit_in = 1'b0;
         page_in = rem_pkg::PG_STATUS;
      end

      // any step or button action forces a redraw base of zero
      draw_clr     = quad.step || act || ret;
      draw_base    = draw_clr ? '0 : last_draw_ff;
      redraw       = (now_ms - draw_base) > {24'd0, cfg.redraw_ms};
      last_draw_in = redraw ? now_ms : draw_base;

      index_wide          = 8'(index_in);
      result.page         = page_in;
      result.edit_index   = index_wide[3:0];
      result.editing      = edit_in;
      result.held_mode    = held_in;
      result.streaming_on = stream_in;
      result.verify_req   = vreq;
      result.fire_req     = freq;
      result.dump_req     = dreq;
      result.map_req      = mreq;
      result.redraw       = redraw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff        <= rem_pkg::PG_STATUS;
         index_ff       <= '0;
         edit_ff        <= 1'b0;
         held_ff        <= 1'b0;
         stream_ff      <= 1'b1;
         last_button_ff <= '0;
         last_draw_ff   <= '0;
         prev_btn_ff    <= 3'b111;
      end else if (upd) begin
         page_ff        <= page_in;
         index_ff       <= index_in;
         edit_ff        <= edit_in;
         held_ff        <= held_in;
         stream_ff      <= stream_in;
         last_button_ff <= last_button_in;
         last_draw_ff   <= last_draw_in;
         prev_btn_ff    <= prev_btn_in;
      end
   end

endmodule

FILE: sv/rotary_encoder_menu_controller.sv
// rotary encoder menu controller: takes one timestamped pin sample per req beat
// and returns one rsp beat with the menu state after that sample. a sample is
// latched into an input register, all decoding (encoder settle, quadrature step,
// button sampling, page action, redraw timer) runs in one pass of logic, and the
// result lands in an output register; the menu state updates in the same cycle.
// rate is one sample per clock while the output register keeps draining; the
// rsp beat follows req accept through the input register, the single pass of
// logic and the output register, which a rsp_tready stall can hold. the input
// register takes a new beat while a finished result still waits on rsp_tready.
// csr writes are always ready and should only be issued while no samples are
// in flight.
module rotary_encoder_menu_controller (
   input  logic        clock,
   input  logic        reset,
   // sample stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] now_ms, [32] enc_a, [33] enc_b, [34] enc_switch,
   // [35] confirm_btn, [36] return_btn, [39:37] zero
   input  logic [39:0] req_tdata,
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] page, [6:3] edit_index, [7] editing, [8] held_mode,
   // [9] streaming_on, [10] verify_req, [11] fire_req, [12] dump_req,
   // [13] map_req, [14] redraw, [15] zero
   output logic [15:0] rsp_tdata,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [9:0]  csr_wdata
);

   // input register
   logic                in_vld_ff;
   logic [36:0]         in_data_ff;
   // output register
   logic                out_vld_ff;
   rem_pkg::result_type out_data_ff;
   // config registers
   rem_pkg::cfg_type    cfg_ff;

   logic                fire;
   rem_pkg::quad_type   quad;
   rem_pkg::result_type result;

   // a sample is processed when the output register is free or draining
   assign fire       = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || fire;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {1'b0, out_data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         if (fire) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata[36:0];
      end
      if (fire) begin
         out_data_ff <= result;
      end
   end

   // config writes, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_hold_ms    <= rem_pkg::SETTLE_RST;
         cfg_ff.button_period_ms <= rem_pkg::BTN_PERIOD_RST;
         cfg_ff.quiet_turn_ms    <= rem_pkg::QUIET_TURN_RST;
         cfg_ff.quiet_change_ms  <= rem_pkg::QUIET_CHANGE_RST;
         cfg_ff.redraw_ms        <= rem_pkg::REDRAW_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            rem_pkg::CSR_SETTLE:       cfg_ff.level_hold_ms    <= csr_wdata[7:0];
            rem_pkg::CSR_BTN_PERIOD:   cfg_ff.button_period_ms <= csr_wdata[7:0];
            rem_pkg::CSR_QUIET_TURN:   cfg_ff.quiet_turn_ms    <= csr_wdata;
            rem_pkg::CSR_QUIET_CHANGE: cfg_ff.quiet_change_ms  <= csr_wdata;
            rem_pkg::CSR_REDRAW:       cfg_ff.redraw_ms        <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // encoder settle and step decode
   rem_quad u_quad (
      .clock         (clock),
      .reset         (reset),
      .upd           (fire),
      .now_ms        (in_data_ff[31:0]),
      .enc_a         (in_data_ff[32]),
      .enc_b         (in_data_ff[33]),
      .level_hold_ms (cfg_ff.level_hold_ms),
      .quad          (quad)
   );

   // buttons, page state and redraw timer
   rem_menu u_menu (
      .clock       (clock),
      .reset       (reset),
      .upd         (fire),
      .now_ms      (in_data_ff[31:0]),
      .enc_switch  (in_data_ff[34]),
      .confirm_btn (in_data_ff[35]),
      .return_btn  (in_data_ff[36]),
      .quad        (quad),
      .cfg         (cfg_ff),
      .result      (result)
   );

endmodule

FILE: sv/rem_checker.sv
`include "rotary_encoder_menu_controller_assert.svh"

module rem_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [39:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [2:0]  csr_index,
   input logic [9:0]  csr_wdata
);

   logic unused_ok;
   assign unused_ok = ^{req_tdata, csr_valid, csr_ready, csr_index, csr_wdata};

   // a stalled result holds its data
   `REM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

   // with one result stalled and one sample taken, no further sample fits
   `REM_ASSERT_NEXT(a_two_deep, clock, reset,
      rsp_tvalid && !rsp_tready && req_tvalid && req_tready, rsp_tready || !req_tready)

   // index editing only happens on the excite page
   `REM_ASSERT_IMP(a_edit_page, clock, reset, rsp_tvalid && rsp_tdata[7],
      rsp_tdata[2:0] == rem_pkg::PG_EXCITE)

endmodule

bind rotary_encoder_menu_controller rem_checker u_rem_checker (.*);

FILE: bench/tb_rotary_encoder_menu_controller.sv
module tb_rotary_encoder_menu_controller;
   timeunit 1ns;
   timeprecision 1ps;

   // cycles with no beat on any channel before the run is called hung
   localparam int STALL_LIMIT   = 2000;
   localparam int DIRECTED_ROWS = 28;
   localparam int PHASES        = 5;
   localparam int PHASE_ITEMS   = 320;

   // button levels in a script row: {return, confirm, switch}, 0 = pressed
   localparam logic [2:0] BTN_NONE  = 3'b111;
   localparam logic [2:0] BTN_CF    = 3'b101;
   localparam logic [2:0] BTN_SW    = 3'b110;
   localparam logic [2:0] BTN_RT    = 3'b011;
   localparam logic [2:0] BTN_CF_SW = 3'b100;
   localparam logic [2:0] BTN_CF_RT = 3'b001;

   // encoder levels {a, b} in gray order, two bits per position
   localparam logic [7:0] WHEEL_SEQ = 8'b10_11_01_00;

   // menu view right after reset: status page, streaming on, nothing else
   localparam rem_pkg::result_type IDLE_VIEW = '{streaming_on: 1'b1, default: '0};
   localparam rem_pkg::result_type NO_VIEW   = '0;

   // one pin sample as it sits in req_tdata, lowest field last
   typedef struct packed {
      logic        return_btn;
      logic        confirm_btn;
      logic        enc_switch;
      logic        enc_b;
      logic        enc_a;
      logic [31:0] now_ms;
   } pin_sample_type;

   typedef struct packed {
      logic [31:0]         now_ms;
      logic [1:0]          ab;
      logic [2:0]          btn;
      logic                typed;
      rem_pkg::result_type want;
   } script_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = '0;
   logic [9:0]  csr_wdata  = '0;

   rotary_encoder_menu_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // menu predictor: own copy of the settings and of the menu state
   // ---------------------------------------------------------------
   rem_pkg::cfg_type menu_cfg = '{rem_pkg::SETTLE_RST, rem_pkg::BTN_PERIOD_RST,
                                  rem_pkg::QUIET_TURN_RST, rem_pkg::QUIET_CHANGE_RST,
                                  rem_pkg::REDRAW_RST};
   logic        level_seen  = 1'b0;
   logic [1:0]  last_lvl    = '0;
   logic [1:0]  settled_lvl = '0;
   logic        settled_ok  = 1'b0;
   logic [31:0] t_change    = '0;
   logic [31:0] t_turn      = '0;
   logic [31:0] t_button    = '0;
   logic [31:0] t_draw      = '0;
   logic        prev_cf     = 1'b1;
   logic        prev_rt     = 1'b1;
   logic        prev_sw     = 1'b1;
   logic [rem_pkg::PAGE_W-1:0] cur_page  = rem_pkg::PG_STATUS;
   logic [rem_pkg::IDX_W-1:0]  cur_index = '0;
   logic        in_edit     = 1'b0;
   logic        held        = 1'b0;
   logic        streaming   = 1'b1;

   // menu views still owed by the block, oldest first
   rem_pkg::result_type expected_views[$];
   int          mismatches    = 0;
   int          views_checked = 0;

   // random sample source state
   logic [31:0] sim_ms        = '0;
   int          wheel_pos     = 0;
   int          wheel_dir     = 1;
   bit          wheel_turning = 1'b0;
   logic [2:0]  btn_levels    = BTN_NONE;
   int          burst_left    = 0;

   script_row_type script [DIRECTED_ROWS];

   function automatic rem_pkg::result_type menu_advance(pin_sample_type s);
      logic [1:0]  lvl;
      logic [31:0] since_change;
      logic [31:0] since_turn;
      logic [31:0] since_button;
      logic [31:0] since_draw;
      logic        stepped;
      logic        step_up;
      logic        quiet;
      logic        hit;
      rem_pkg::result_type v;
      lvl     = {s.enc_a, s.enc_b};
      stepped = 1'b0;
      step_up = 1'b0;
      v       = '0;

      // the very first sample always counts as a raw change
      if (!level_seen || lvl != last_lvl) begin
         level_seen = 1'b1;
         last_lvl   = lvl;
         t_change   = s.now_ms;
      end

      since_change = s.now_ms - t_change;
      if (since_change >= 32'(menu_cfg.level_hold_ms)) begin
         if (!settled_ok) begin
            // first settle only records the level
            settled_lvl = lvl;
            settled_ok  = 1'b1;
         end else if (lvl != settled_lvl) begin
            // down steps of the gray sequence; any other change, the
            // two-bit jump included, counts as up
            case ({settled_lvl, lvl})
               4'b0001, 4'b0111, 4'b1000, 4'b1110: step_up = 1'b0;
               default:                            step_up = 1'b1;
            endcase
            stepped     = 1'b1;
            settled_lvl = lvl;
            t_turn      = s.now_ms;
         end
      end

      if (stepped) begin
         if (in_edit && cur_page == rem_pkg::PG_EXCITE) begin
            if (step_up)
               cur_index = (cur_index >= rem_pkg::INDEX_LAST) ? '0 : cur_index + 1'b1;
            else
               cur_index = (cur_index == '0 || cur_index > rem_pkg::INDEX_LAST) ?
                           rem_pkg::INDEX_LAST : cur_index - 1'b1;
         end else begin
            in_edit = 1'b0;
            if (step_up)
               cur_page = (cur_page >= rem_pkg::PAGE_LAST) ?
                          rem_pkg::PG_STATUS : cur_page + 1'b1;
            else
               cur_page = (cur_page == rem_pkg::PG_STATUS) ?
                          rem_pkg::PAGE_LAST : cur_page - 1'b1;
         end
         t_draw = '0;
      end

      since_button = s.now_ms - t_button;
      if (since_button > 32'(menu_cfg.button_period_ms)) begin
         t_button   = s.now_ms;
         since_turn = s.now_ms - t_turn;
         quiet = (since_turn > 32'(menu_cfg.quiet_turn_ms)) &&
                 (s.now_ms - t_change > 32'(menu_cfg.quiet_change_ms));
         hit   = (!s.confirm_btn && prev_cf) || (!s.enc_switch && prev_sw);
         if (quiet && hit) begin
            case (cur_page)
               rem_pkg::PG_IDENTITY:  v.verify_req = 1'b1;
               rem_pkg::PG_MODE:      held = !held;
               rem_pkg::PG_EXCITE: begin
                  if (!in_edit) begin
                     in_edit = 1'b1;
                  end else begin
                     in_edit    = 1'b0;
                     v.fire_req = 1'b1;
                  end
               end
               rem_pkg::PG_STREAM:    streaming = !streaming;
               rem_pkg::PG_DUMP:      v.dump_req = 1'b1;
               rem_pkg::PG_CALIBRATE: v.map_req = 1'b1;
               default: ;
            endcase
            t_draw = '0;
         end
         if (!s.return_btn && prev_rt) begin
            in_edit  = 1'b0;
            cur_page = rem_pkg::PG_STATUS;
            t_draw   = '0;
         end
         prev_cf = s.confirm_btn;
         prev_rt = s.return_btn;
         prev_sw = s.enc_switch;
      end

      since_draw = s.now_ms - t_draw;
      if (since_draw > 32'(menu_cfg.redraw_ms)) begin
         t_draw   = s.now_ms;
         v.redraw = 1'b1;
      end

      v.page         = cur_page;
      v.edit_index   = cur_index;
      v.editing      = in_edit;
      v.held_mode    = held;
      v.streaming_on = streaming;
      return v;
   endfunction

   // ---------------------------------------------------------------
   // random pin samples: mostly clean detents and button presses,
   // with some contact bounce and wild time jumps mixed in
   // ---------------------------------------------------------------
   function automatic pin_sample_type next_random_sample();
      int unsigned    roll;
      int unsigned    scale;
      logic [31:0]    step_ms;
      logic [1:0]     lvl;
      pin_sample_type s;
      scale = menu_cfg.level_hold_ms + menu_cfg.button_period_ms + 8;
      roll  = $urandom_range(0, 99);
      if (roll < 40)      step_ms = $urandom_range(0, 3);
      else if (roll < 75) step_ms = $urandom_range(0, scale);
      else if (roll < 95) step_ms = $urandom_range(0, 4 * scale);
      else if (roll < 99) step_ms = $urandom_range(0, 1500);
      else                step_ms = $urandom;
      sim_ms = sim_ms + step_ms;

      // alternate between turning the knob and leaving it alone
      if ($urandom_range(0, 99) < 6) wheel_turning = !wheel_turning;
      if (wheel_turning) begin
         if ($urandom_range(0, 99) < 5) wheel_dir = -wheel_dir;
         if ($urandom_range(0, 99) < 30) wheel_pos = (wheel_pos + wheel_dir + 4) % 4;
      end
      lvl = WHEEL_SEQ[2*wheel_pos +: 2];
      // bounce: a stray level for one sample, two-bit jumps included
      if ($urandom_range(0, 99) < (wheel_turning ? 4 : 2)) lvl = 2'($urandom_range(0, 3));

      for (int b = 0; b < 3; b++)
         if ($urandom_range(0, 99) < (wheel_turning ? 4 : 10)) btn_levels[b] = !btn_levels[b];

      s.now_ms = sim_ms;
      {s.enc_a, s.enc_b} = lvl;
      {s.return_btn, s.confirm_btn, s.enc_switch} = btn_levels;
      return s;
   endfunction

   function automatic rem_pkg::cfg_type phase_setting(int ph);
      case (ph)
         0:       return '{8'd0, 8'd0, 10'd0, 10'd0, 8'd0};
         1:       return '{8'd255, 8'd255, 10'd1023, 10'd1023, 8'd255};
         2:       return '{8'd2, 8'd3, 10'd20, 10'd8, 8'd5};
         3:       return '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                           8'($urandom_range(0, 255))};
         default: return '{rem_pkg::SETTLE_RST, rem_pkg::BTN_PERIOD_RST,
                           rem_pkg::QUIET_TURN_RST, rem_pkg::QUIET_CHANGE_RST,
                           rem_pkg::REDRAW_RST};
      endcase
   endfunction

   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
   endfunction

   // ---------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------

   // one sample beat; valid stays up afterwards so back-to-back beats
   // never drop it in between
   task automatic put_sample(input pin_sample_type s, input logic typed,
                             input rem_pkg::result_type fixed);
      rem_pkg::result_type v;
      @(negedge clock);
      req_tdata  <= {3'b000, s};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      v = menu_advance(s);
      expected_views.push_back(typed ? fixed : v);
   endtask

   // bursts of random length separated by random gaps, some of them zero
   task automatic sender_gap();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   // hold the sender until every owed view is back, plus a short tail
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // all five registers back to back on the csr channel
   task automatic write_settings(input rem_pkg::cfg_type c);
      logic [2:0] idx  [5];
      logic [9:0] vals [5];
      idx  = '{rem_pkg::CSR_SETTLE, rem_pkg::CSR_BTN_PERIOD, rem_pkg::CSR_QUIET_TURN,
               rem_pkg::CSR_QUIET_CHANGE, rem_pkg::CSR_REDRAW};
      vals = '{10'(c.level_hold_ms), 10'(c.button_period_ms), c.quiet_turn_ms,
               c.quiet_change_ms, 10'(c.redraw_ms)};
      for (int i = 0; i < 5; i++) begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (idx[i])
            rem_pkg::CSR_SETTLE:       menu_cfg.level_hold_ms    = vals[i][7:0];
            rem_pkg::CSR_BTN_PERIOD:   menu_cfg.button_period_ms = vals[i][7:0];
            rem_pkg::CSR_QUIET_TURN:   menu_cfg.quiet_turn_ms    = vals[i];
            rem_pkg::CSR_QUIET_CHANGE: menu_cfg.quiet_change_ms  = vals[i];
            rem_pkg::CSR_REDRAW:       menu_cfg.redraw_ms        = vals[i][7:0];
            default: ;
         endcase
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   initial begin : stimulus
      pin_sample_type s;

      // walk through every page action with reset settings; timing keeps
      // each press outside the quiet window unless noted
      script = '{
         // reset view, nothing has had time to happen
         '{32'd0,    2'b00, BTN_NONE,  1'b1, IDLE_VIEW},
         // first settle, level recorded without a step
         '{32'd30,   2'b00, BTN_NONE,  1'b0, NO_VIEW},
         // confirm on the status page: no action, forced redraw
         '{32'd260,  2'b00, BTN_CF,    1'b0, NO_VIEW},
         '{32'd300,  2'b01, BTN_NONE,  1'b0, NO_VIEW},
         // step down from status wraps to calibrate
         '{32'd330,  2'b01, BTN_NONE,  1'b0, NO_VIEW},
         '{32'd640,  2'b01, BTN_CF,    1'b0, NO_VIEW},   // map request
         '{32'd680,  2'b11, BTN_NONE,  1'b0, NO_VIEW},
         '{32'd710,  2'b11, BTN_NONE,  1'b0, NO_VIEW},   // down to dump
         // confirm and switch together, one dump request only
         '{32'd1040, 2'b11, BTN_CF_SW, 1'b0, NO_VIEW},
         '{32'd1080, 2'b10, BTN_NONE,  1'b0, NO_VIEW},
         '{32'd1110, 2'b10, BTN_NONE,  1'b0, NO_VIEW},   // down to stream
         '{32'd1440, 2'b10, BTN_SW,    1'b0, NO_VIEW},   // streaming toggles off
         // return goes to status; both encoder bits flip here
         '{32'd1480, 2'b01, BTN_RT,    1'b0, NO_VIEW},
         // two-bit jump steps up; confirm edge lost in the quiet window
         '{32'd1520, 2'b01, BTN_CF,    1'b0, NO_VIEW},
         '{32'd1900, 2'b01, BTN_NONE,  1'b0, NO_VIEW},
         '{32'd1940, 2'b01, BTN_CF,    1'b0, NO_VIEW},   // verify request
         '{32'd1980, 2'b00, BTN_NONE,  1'b0, NO_VIEW},
         '{32'd2010, 2'b00, BTN_NONE,  1'b0, NO_VIEW},   // up to mode
         '{32'd2340, 2'b00, BTN_CF,    1'b0, NO_VIEW},   // held toggles
         '{32'd2380, 2'b10, BTN_NONE,  1'b0, NO_VIEW},
         '{32'd2410, 2'b10, BTN_NONE,  1'b0, NO_VIEW},   // up to excite
         '{32'd2740, 2'b10, BTN_CF,    1'b0, NO_VIEW},   // editing on
         '{32'd2780, 2'b00, BTN_NONE,  1'b0, NO_VIEW},
         '{32'd2810, 2'b00, BTN_NONE,  1'b0, NO_VIEW},   // index below 0 wraps to max
         '{32'd2850, 2'b10, BTN_NONE,  1'b0, NO_VIEW},
         '{32'd2880, 2'b10, BTN_NONE,  1'b0, NO_VIEW},   // index above max wraps to 0
         // confirm and return together: fire pulse, then back to status
         '{32'd3200, 2'b10, BTN_CF_RT, 1'b0, NO_VIEW},
         // top of the time range
         '{32'hFFFF_FFFF, 2'b01, BTN_NONE, 1'b0, NO_VIEW}
      };

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int n = 0; n < DIRECTED_ROWS; n++) begin
         sender_gap();
         s.now_ms = script[n].now_ms;
         {s.enc_a, s.enc_b} = script[n].ab;
         {s.return_btn, s.confirm_btn, s.enc_switch} = script[n].btn;
         put_sample(s, script[n].typed, script[n].want);
      end
      sim_ms = script[DIRECTED_ROWS-1].now_ms;

      // settings phases: all zero, all max, small, random, back to reset
      for (int ph = 0; ph < PHASES; ph++) begin
         drain_results();
         write_settings(phase_setting(ph));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sender also waits for the block to empty once partway through each phase
            if (n == 100) drain_results();
            sender_gap();
            put_sample(next_random_sample(), 1'b0, NO_VIEW);
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_views.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------
   // receiver side: segments of always ready, coin flip and sparse ready,
   // plus one long hold-off while the sender keeps pushing
   // ---------------------------------------------------------------
   initial begin : ready_pattern
      int seg_len;
      int mode;
      bit long_done;
      long_done = 1'b0;
      forever begin
         if (!long_done && views_checked >= 400) begin
            long_done = 1'b1;
            // block fills up and must stall req_tready
            repeat (120) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
            end
         end
         seg_len = $urandom_range(4, 40);
         mode    = $urandom_range(0, 2);
         repeat (seg_len) begin
            @(negedge clock);
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------
   // result check, field by field against the oldest owed view
   // ---------------------------------------------------------------
   always @(posedge clock) begin : view_check
      rem_pkg::result_type got;
      rem_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rem_pkg::result_type'(rsp_tdata[14:0]);
         views_checked++;
         if (expected_views.size() == 0) begin
            mismatches++;
            $display("%0t: rsp beat with nothing expected, expected none got %h",
                     $time, rsp_tdata);
         end else begin
            want = expected_views.pop_front();
            compare_field("page",         want.page,         got.page);
            compare_field("edit_index",   want.edit_index,   got.edit_index);
            compare_field("editing",      want.editing,      got.editing);
            compare_field("held_mode",    want.held_mode,    got.held_mode);
            compare_field("streaming_on", want.streaming_on, got.streaming_on);
            compare_field("verify_req",   want.verify_req,   got.verify_req);
            compare_field("fire_req",     want.fire_req,     got.fire_req);
            compare_field("dump_req",     want.dump_req,     got.dump_req);
            compare_field("map_req",      want.map_req,      got.map_req);
            compare_field("redraw",       want.redraw,       got.redraw);
         end
      end
   end

   // watchdog: too long without any beat on any channel means a hang
   int idle_cycles_seen = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles_seen <= 0;
      end else if (idle_cycles_seen >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles_seen <= idle_cycles_seen + 1;
      end
   end

endmodule

FILE: sim.f
+incdir+sv
sv/rem_pkg.sv
sv/rem_quad.sv
sv/rem_menu.sv
sv/rotary_encoder_menu_controller.sv
sv/rem_checker.sv
bench/tb_rotary_encoder_menu_controller.sv
